// ----- sv/lfrs_pkg.sv -----
// Shared types, widths and constants for the line follow route sequencer.
package lfrs_pkg;

    localparam int OP_W       = 2;
    localparam int BITS_W     = 8;
    localparam int YAW_W      = 16;
    localparam int SPD_W      = 9;
    localparam int ERR_W      = 10;
    localparam int STEP_W     = 4;
    localparam int CNT_W      = 8;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 8;
    localparam int ANGLE_W    = 16;
    localparam int TICK_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int CHAN_N     = 8;
    localparam int SUM_W      = 11;
    localparam int MAG_W      = 9;
    localparam int DVD_W      = 10;
    localparam int DIVR_W     = 4;
    localparam int PROD_W     = MAG_W + GAIN_W;
    localparam int DIV_STEPS  = DVD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic signed [SUM_W-1:0] CHAN_WEIGHT [CHAN_N] = '{
        -11'sd380, -11'sd250, -11'sd150, -11'sd50,
        11'sd50, 11'sd150, 11'sd250, 11'sd380
    };

    localparam logic signed [ERR_W-1:0] LOST_ERROR = 10'sd400;
    localparam logic [BITS_W-1:0]       ALL_WHITE  = 8'hFF;
    localparam logic [STEP_W-1:0]       ROUTE_LAST = 4'd9;
    localparam logic [TICK_W-1:0]       TICK_MAX   = 4'd15;

    localparam logic signed [SPD_W-1:0] BASE_SPEED_RST      = 9'sd130;
    localparam logic [GAIN_W-1:0]       LINE_GAIN_RST       = 16'd5243;
    localparam logic [LIMIT_W-1:0]      LINE_TURN_LIMIT_RST = 8'd40;
    localparam logic [LIMIT_W-1:0]      FIND_TURN_LIMIT_RST = 8'd6;
    localparam logic signed [SPD_W-1:0] SPIN_SPEED_RST      = 9'sd50;
    localparam logic signed [SPD_W-1:0] SEEK_SPEED_RST      = 9'sd40;
    localparam logic [ANGLE_W-1:0]      CORNER_ANGLE_RST    = 16'd4500;
    localparam logic [TICK_W-1:0]       CONFIRM_TICKS_RST   = 4'd2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_TOGGLE = 2'd1,
        OP_ESTOP  = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_SPEED      = 3'd0,
        REG_LINE_GAIN       = 3'd1,
        REG_LINE_TURN_LIMIT = 3'd2,
        REG_FIND_TURN_LIMIT = 3'd3,
        REG_SPIN_SPEED      = 3'd4,
        REG_SEEK_SPEED      = 3'd5,
        REG_CORNER_ANGLE    = 3'd6,
        REG_CONFIRM_TICKS   = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        KIND_LINE,
        KIND_SPIN,
        KIND_SEEK,
        KIND_WRAP,
        KIND_BAD
    } route_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_BRANCH,
        ST_DIV,
        ST_ERR,
        ST_MUL,
        ST_STEER,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_step;
        logic err_fin;
        logic mul;
        logic steer;
        logic push;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_steer;
        logic need_div;
        logic div_last;
        logic out_free;
    } ctrl_status_t;

endpackage

// ----- sv/lfrs_sensor_if.sv -----
// Input channel: operation code, line sensor sample and yaw.
interface lfrs_sensor_if;
    import lfrs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic [BITS_W-1:0]       sensor_bits;
    logic signed [YAW_W-1:0] yaw;

    modport source (output valid, output operation, output sensor_bits, output yaw,
                    input ready);
    modport sink (input valid, input operation, input sensor_bits, input yaw,
                  output ready);
endinterface

// ----- sv/lfrs_drive_if.sv -----
// Output channel: wheel targets, line error and route status.
interface lfrs_drive_if;
    import lfrs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SPD_W-1:0] left_target;
    logic signed [SPD_W-1:0] right_target;
    logic signed [ERR_W-1:0] line_error;
    logic                    line_lost;
    logic [STEP_W-1:0]       route_step;
    logic [CNT_W-1:0]        corner_total;
    logic                    running;

    modport source (output valid, output left_target, output right_target,
                    output line_error, output line_lost, output route_step,
                    output corner_total, output running, input ready);
    modport sink (input valid, input left_target, input right_target,
                  input line_error, input line_lost, input route_step,
                  input corner_total, input running, output ready);
endinterface

// ----- sv/line_follow_route_sequencer.sv -----
// Top level: line follower route sequencer with centroid steering.
//
//   channel   dir  handshake      contents
//   sensor    in   valid/ready    operation, sensor_bits, yaw
//   drive     out  valid/ready    wheel targets, line error, lost, step, corners, running
//   cfg       in   cfg_we         cfg_index selects register, cfg_data value
//
// One transfer at a time: a steering tick that sees the line runs from accept through
// the bit-serial centroid divider and the gain multiply to the result. A lost-line
// steering tick skips the divider; any other tick or event skips steering altogether.
// The block is ready again in the cycle after the result is pushed to the output register.
// rst_n clears route state and loads register defaults; no clearing pass.
// A stalled drive channel holds the next result until the output register frees.
module line_follow_route_sequencer #(
    parameter int SPEED_LIMIT    = 200,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lfrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lfrs_pkg::CFG_DATA_W-1:0] cfg_data,
    lfrs_sensor_if.sink                     sensor,
    lfrs_drive_if.source                    drive
);
    import lfrs_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    lfrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sensor.valid),
        .in_ready (sensor.ready),
        .status   (status),
        .cmd      (cmd)
    );

    lfrs_dp #(
        .SPEED_LIMIT    (SPEED_LIMIT),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .operation    (sensor.operation),
        .sensor_bits  (sensor.sensor_bits),
        .yaw          (sensor.yaw),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (drive.valid),
        .out_ready    (drive.ready),
        .left_target  (drive.left_target),
        .right_target (drive.right_target),
        .line_error   (drive.line_error),
        .line_lost    (drive.line_lost),
        .route_step   (drive.route_step),
        .corner_total (drive.corner_total),
        .running      (drive.running)
    );

endmodule

// ----- sv/lfrs_ctrl.sv -----
// Controller state machine sequencing one transfer through the datapath.
module lfrs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lfrs_pkg::ctrl_status_t status,
    output lfrs_pkg::ctrl_cmd_t    cmd
);
    import lfrs_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_BRANCH;
            end
            ST_BRANCH:
            begin
                if (!status.need_steer)
                begin
                    state_next = ST_EMIT;
                end
                else if (status.need_div)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_ERR;
                end
            end
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_STEER;
            end
            ST_STEER:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            ST_BRANCH:
            begin
                cmd = '0;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_ERR:
            begin
                cmd.err_fin = 1'b1;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            ST_STEER:
            begin
                cmd.steer = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.push = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTH
    a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=> (state_reg == ST_EVAL))
        else $error("accepted transfer did not start evaluation");

    a_div_to_err: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && status.div_last) |=> (state_reg == ST_ERR))
        else $error("divider finish did not advance to error stage");

    a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && status.out_free) |=> (state_reg == ST_IDLE))
        else $error("result push did not return to idle");
`endif

endmodule

// ----- sv/lfrs_dp.sv -----
// Datapath: route state, centroid divider, gain multiplier and wheel clamps.
module lfrs_dp #(
    parameter int SPEED_LIMIT    = 200,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [lfrs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lfrs_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic [lfrs_pkg::OP_W-1:0]              operation,
    input  logic [lfrs_pkg::BITS_W-1:0]            sensor_bits,
    input  logic signed [lfrs_pkg::YAW_W-1:0]      yaw,
    input  lfrs_pkg::ctrl_cmd_t                    cmd,
    output lfrs_pkg::ctrl_status_t                 status,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [lfrs_pkg::SPD_W-1:0]      left_target,
    output logic signed [lfrs_pkg::SPD_W-1:0]      right_target,
    output logic signed [lfrs_pkg::ERR_W-1:0]      line_error,
    output logic                                   line_lost,
    output logic [lfrs_pkg::STEP_W-1:0]            route_step,
    output logic [lfrs_pkg::CNT_W-1:0]             corner_total,
    output logic                                   running
);
    import lfrs_pkg::*;

    localparam int LIM_BASE_W = $clog2(SPEED_LIMIT + 1) + 1;
    localparam int LIM_W      = (LIM_BASE_W > SUM_W) ? LIM_BASE_W : SUM_W;
    localparam logic signed [LIM_W-1:0] SPD_LIM  = LIM_W'(SPEED_LIMIT);
    localparam logic signed [LIM_W-1:0] SPD_NLIM = LIM_W'(-SPEED_LIMIT);
    localparam int DIFF_W = YAW_W + 1;

    function automatic logic signed [SPD_W-1:0] clamp_spd(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [LIM_W-1:0] w;
        logic signed [LIM_W-1:0] c;
        w = LIM_W'(v);
        if (w > SPD_LIM)
        begin
            c = SPD_LIM;
        end
        else if (w < SPD_NLIM)
        begin
            c = SPD_NLIM;
        end
        else
        begin
            c = w;
        end
        return c[SPD_W-1:0];
    endfunction

    function automatic logic [TICK_W:0] confirm_step(
        input logic [TICK_W-1:0] ctr,
        input logic              hit,
        input logic [TICK_W-1:0] need
    );
        logic [TICK_W-1:0] inc;
        logic [TICK_W:0]   res;
        inc = ctr;
        res = '0;
        if (hit)
        begin
            if (ctr < TICK_MAX)
            begin
                inc = ctr + 1'b1;
            end
            if (inc >= need)
            begin
                res = {1'b1, {TICK_W{1'b0}}};
            end
            else
            begin
                res = {1'b0, inc};
            end
        end
        return res;
    endfunction

    function automatic route_kind_t route_kind(input logic [STEP_W-1:0] rs);
        route_kind_t k;
        case (rs) inside
            4'd0, 4'd3, 4'd6: k = KIND_LINE;
            4'd1, 4'd4, 4'd7: k = KIND_SPIN;
            4'd2, 4'd5, 4'd8: k = KIND_SEEK;
            4'd9:             k = KIND_WRAP;
            default:          k = KIND_BAD;
        endcase
        return k;
    endfunction

    logic signed [SPD_W-1:0]   base_speed_reg;
    logic [GAIN_W-1:0]         line_gain_reg;
    logic [LIMIT_W-1:0]        line_turn_limit_reg;
    logic [LIMIT_W-1:0]        find_turn_limit_reg;
    logic signed [SPD_W-1:0]   spin_speed_reg;
    logic signed [SPD_W-1:0]   seek_speed_reg;
    logic [ANGLE_W-1:0]        corner_angle_reg;
    logic [TICK_W-1:0]         confirm_ticks_reg;

    logic [OP_W-1:0]           op_reg;
    logic [BITS_W-1:0]         bits_reg;
    logic signed [YAW_W-1:0]   yaw_reg;

    logic                      run_flag_reg, run_flag_next;
    logic [STEP_W-1:0]         route_state_reg, route_state_next;
    logic signed [YAW_W-1:0]   heading_ref_reg, heading_ref_next;
    logic signed [ERR_W-1:0]   prev_error_reg, prev_error_next;
    logic [TICK_W-1:0]         lost_ticks_reg, lost_ticks_next;
    logic [TICK_W-1:0]         found_ticks_reg, found_ticks_next;
    logic [CNT_W-1:0]          corner_counter_reg, corner_counter_next;
    logic signed [SPD_W-1:0]   left_speed_reg, left_speed_next;
    logic signed [SPD_W-1:0]   right_speed_reg, right_speed_next;
    logic signed [ERR_W-1:0]   shown_error_reg, shown_error_next;
    logic                      lost_mark_reg, lost_mark_next;
    logic                      need_steer_reg, need_steer_next;
    logic                      need_div_reg, need_div_next;
    logic                      out_valid_reg;

    logic                      lost_pend_reg;
    logic                      sum_neg_reg;
    logic                      steer_seek_reg;
    logic [DVD_W-1:0]          quo_reg;
    logic [DIVR_W-1:0]         rem_reg;
    logic [DIVR_W-1:0]         divisor_reg;
    logic [DIV_CNT_W-1:0]      div_cnt_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic                      err_neg_reg;
    logic [PROD_W-1:0]         prod_reg;

    logic signed [SPD_W-1:0]   o_left_reg, o_right_reg;
    logic signed [ERR_W-1:0]   o_error_reg;
    logic                      o_lost_reg;
    logic [STEP_W-1:0]         o_step_reg;
    logic [CNT_W-1:0]          o_corner_reg;
    logic                      o_running_reg;

    logic                      white;
    logic signed [SUM_W-1:0]   chan_sum;
    logic [DIVR_W-1:0]         chan_cnt;
    logic [DVD_W-1:0]          sum_mag;
    route_kind_t               kind;
    logic [TICK_W:0]           line_conf;
    logic [TICK_W:0]           seek_conf;
    logic signed [SUM_W-1:0]   spin_ext, spin_neg, seek_ext;
    logic signed [DIFF_W-1:0]  yaw_diff;
    logic [DIFF_W-1:0]         yaw_delta;
    logic [DIVR_W:0]           div_shift;
    logic                      div_ge;
    logic [DIVR_W-1:0]         div_rem;
    logic signed [ERR_W-1:0]   quo_s;
    logic signed [ERR_W-1:0]   err_val;
    logic [MAG_W-1:0]          err_mag;
    logic [PROD_W-1:0]         prod_shift;
    logic [LIMIT_W-1:0]        steer_limit;
    logic [LIMIT_W-1:0]        turn_mag;
    logic signed [SUM_W-1:0]   turn_s;
    logic signed [SUM_W-1:0]   steer_base;
    logic signed [SUM_W-1:0]   left_sum, right_sum;

    always_comb
    begin
        chan_sum = '0;
        chan_cnt = '0;
        for (int i = 0; i < CHAN_N; i++)
        begin
            if (!bits_reg[i])
            begin
                chan_sum = chan_sum + CHAN_WEIGHT[i];
                chan_cnt = chan_cnt + 1'b1;
            end
        end
    end

    assign white     = (bits_reg == ALL_WHITE);
    assign sum_mag   = chan_sum[SUM_W-1] ? DVD_W'(-chan_sum) : chan_sum[DVD_W-1:0];
    assign kind      = route_kind(route_state_reg);
    assign line_conf = confirm_step(lost_ticks_reg, white, confirm_ticks_reg);
    assign seek_conf = confirm_step(found_ticks_reg, !white, confirm_ticks_reg);
    assign spin_ext  = SUM_W'(spin_speed_reg);
    assign spin_neg  = -spin_ext;
    assign seek_ext  = SUM_W'(seek_speed_reg);
    assign yaw_diff  = DIFF_W'(yaw_reg) - DIFF_W'(heading_ref_reg);
    assign yaw_delta = yaw_diff[DIFF_W-1] ? DIFF_W'(-yaw_diff) : yaw_diff;

    assign div_shift = {rem_reg, quo_reg[DVD_W-1]};
    assign div_ge    = (div_shift >= {1'b0, divisor_reg});
    assign div_rem   = div_ge ? DIVR_W'(div_shift - {1'b0, divisor_reg})
                              : div_shift[DIVR_W-1:0];

    assign quo_s = $signed(quo_reg);

    always_comb
    begin
        if (lost_pend_reg)
        begin
            if (prev_error_reg > 0)
            begin
                err_val = LOST_ERROR;
            end
            else if (prev_error_reg < 0)
            begin
                err_val = -LOST_ERROR;
            end
            else
            begin
                err_val = '0;
            end
        end
        else
        begin
            err_val = sum_neg_reg ? -quo_s : quo_s;
        end
    end

    assign err_mag = err_val[ERR_W-1] ? MAG_W'(-err_val) : err_val[MAG_W-1:0];

    assign prod_shift  = prod_reg >> GAIN_FRAC_BITS;
    assign steer_limit = steer_seek_reg ? find_turn_limit_reg : line_turn_limit_reg;
    assign turn_mag    = (prod_shift > PROD_W'(steer_limit)) ? steer_limit
                                                             : prod_shift[LIMIT_W-1:0];
    assign turn_s      = err_neg_reg ? -SUM_W'(turn_mag) : SUM_W'(turn_mag);
    assign steer_base  = SUM_W'(steer_seek_reg ? seek_speed_reg : base_speed_reg);
    assign left_sum    = steer_base + turn_s;
    assign right_sum   = steer_base - turn_s;

    always_comb
    begin
        run_flag_next       = run_flag_reg;
        route_state_next    = route_state_reg;
        heading_ref_next    = heading_ref_reg;
        prev_error_next     = prev_error_reg;
        lost_ticks_next     = lost_ticks_reg;
        found_ticks_next    = found_ticks_reg;
        corner_counter_next = corner_counter_reg;
        left_speed_next     = left_speed_reg;
        right_speed_next    = right_speed_reg;
        shown_error_next    = shown_error_reg;
        lost_mark_next      = lost_mark_reg;
        need_steer_next     = need_steer_reg;
        need_div_next       = need_div_reg;

        if (cmd.eval)
        begin
            need_steer_next = 1'b0;
            need_div_next   = 1'b0;
            case (op_t'(op_reg))
                OP_TICK:
                begin
                    if (!run_flag_reg)
                    begin
                        left_speed_next  = '0;
                        right_speed_next = '0;
                    end
                    else
                    begin
                        case (kind)
                            KIND_LINE:
                            begin
                                lost_ticks_next = line_conf[TICK_W-1:0];
                                if (line_conf[TICK_W])
                                begin
                                    corner_counter_next = corner_counter_reg + 1'b1;
                                    heading_ref_next    = yaw_reg;
                                    route_state_next    = route_state_reg + 1'b1;
                                end
                                else
                                begin
                                    need_steer_next = 1'b1;
                                    need_div_next   = !white;
                                end
                            end
                            KIND_SPIN:
                            begin
                                left_speed_next  = clamp_spd(spin_ext);
                                right_speed_next = clamp_spd(spin_neg);
                                if (yaw_delta >= DIFF_W'(corner_angle_reg))
                                begin
                                    route_state_next = route_state_reg + 1'b1;
                                end
                            end
                            KIND_SEEK:
                            begin
                                if (!white)
                                begin
                                    need_steer_next = 1'b1;
                                    need_div_next   = 1'b1;
                                end
                                else
                                begin
                                    left_speed_next  = clamp_spd(seek_ext);
                                    right_speed_next = clamp_spd(seek_ext);
                                end
                                found_ticks_next = seek_conf[TICK_W-1:0];
                                if (seek_conf[TICK_W])
                                begin
                                    heading_ref_next = yaw_reg;
                                    route_state_next = route_state_reg + 1'b1;
                                end
                            end
                            KIND_WRAP:
                            begin
                                route_state_next = '0;
                            end
                            default:
                            begin
                                left_speed_next  = '0;
                                right_speed_next = '0;
                            end
                        endcase
                    end
                end
                OP_TOGGLE:
                begin
                    run_flag_next = !run_flag_reg;
                    if (!run_flag_reg)
                    begin
                        route_state_next = '0;
                        heading_ref_next = yaw_reg;
                    end
                end
                OP_ESTOP:
                begin
                    run_flag_next    = 1'b0;
                    left_speed_next  = '0;
                    right_speed_next = '0;
                end
                default:
                begin
                    run_flag_next = run_flag_reg;
                end
            endcase
        end

        if (cmd.err_fin)
        begin
            shown_error_next = err_val;
            lost_mark_next   = lost_pend_reg;
            if (!lost_pend_reg)
            begin
                prev_error_next = err_val;
            end
        end

        if (cmd.steer)
        begin
            left_speed_next  = clamp_spd(left_sum);
            right_speed_next = clamp_spd(right_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_speed_reg      <= BASE_SPEED_RST;
            line_gain_reg       <= LINE_GAIN_RST;
            line_turn_limit_reg <= LINE_TURN_LIMIT_RST;
            find_turn_limit_reg <= FIND_TURN_LIMIT_RST;
            spin_speed_reg      <= SPIN_SPEED_RST;
            seek_speed_reg      <= SEEK_SPEED_RST;
            corner_angle_reg    <= CORNER_ANGLE_RST;
            confirm_ticks_reg   <= CONFIRM_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BASE_SPEED:      base_speed_reg      <= cfg_data[SPD_W-1:0];
                REG_LINE_GAIN:       line_gain_reg       <= cfg_data[GAIN_W-1:0];
                REG_LINE_TURN_LIMIT: line_turn_limit_reg <= cfg_data[LIMIT_W-1:0];
                REG_FIND_TURN_LIMIT: find_turn_limit_reg <= cfg_data[LIMIT_W-1:0];
                REG_SPIN_SPEED:      spin_speed_reg      <= cfg_data[SPD_W-1:0];
                REG_SEEK_SPEED:      seek_speed_reg      <= cfg_data[SPD_W-1:0];
                REG_CORNER_ANGLE:    corner_angle_reg    <= cfg_data[ANGLE_W-1:0];
                REG_CONFIRM_TICKS:   confirm_ticks_reg   <= cfg_data[TICK_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_flag_reg       <= 1'b0;
            route_state_reg    <= '0;
            heading_ref_reg    <= '0;
            prev_error_reg     <= '0;
            lost_ticks_reg     <= '0;
            found_ticks_reg    <= '0;
            corner_counter_reg <= '0;
            left_speed_reg     <= '0;
            right_speed_reg    <= '0;
            shown_error_reg    <= '0;
            lost_mark_reg      <= 1'b0;
            need_steer_reg     <= 1'b0;
            need_div_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            run_flag_reg       <= run_flag_next;
            route_state_reg    <= route_state_next;
            heading_ref_reg    <= heading_ref_next;
            prev_error_reg     <= prev_error_next;
            lost_ticks_reg     <= lost_ticks_next;
            found_ticks_reg    <= found_ticks_next;
            corner_counter_reg <= corner_counter_next;
            left_speed_reg     <= left_speed_next;
            right_speed_reg    <= right_speed_next;
            shown_error_reg    <= shown_error_next;
            lost_mark_reg      <= lost_mark_next;
            need_steer_reg     <= need_steer_next;
            need_div_reg       <= need_div_next;
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            bits_reg <= sensor_bits;
            yaw_reg  <= yaw;
        end
        if (cmd.eval)
        begin
            quo_reg        <= sum_mag;
            rem_reg        <= '0;
            divisor_reg    <= chan_cnt;
            div_cnt_reg    <= '0;
            sum_neg_reg    <= (chan_sum < 0);
            lost_pend_reg  <= white;
            steer_seek_reg <= (kind == KIND_SEEK);
        end
        if (cmd.div_step)
        begin
            quo_reg     <= {quo_reg[DVD_W-2:0], div_ge};
            rem_reg     <= div_rem;
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (cmd.err_fin)
        begin
            mag_reg     <= err_mag;
            err_neg_reg <= err_val[ERR_W-1];
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(line_gain_reg);
        end
        if (cmd.push)
        begin
            o_left_reg    <= left_speed_reg;
            o_right_reg   <= right_speed_reg;
            o_error_reg   <= shown_error_reg;
            o_lost_reg    <= lost_mark_reg;
            o_step_reg    <= route_state_reg;
            o_corner_reg  <= corner_counter_reg;
            o_running_reg <= run_flag_reg;
        end
    end

    assign status.need_steer = need_steer_reg;
    assign status.need_div   = need_div_reg;
    assign status.div_last   = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign left_target  = o_left_reg;
    assign right_target = o_right_reg;
    assign line_error   = o_error_reg;
    assign line_lost    = o_lost_reg;
    assign route_step   = o_step_reg;
    assign corner_total = o_corner_reg;
    assign running      = o_running_reg;

`ifndef SYNTH
    a_route_range: assert property (@(posedge clk) disable iff (!rst_n)
        route_state_reg <= ROUTE_LAST)
        else $error("route step beyond last leg");

    a_lost_error: assert property (@(posedge clk) disable iff (!rst_n)
        lost_mark_reg |-> (shown_error_reg == LOST_ERROR ||
                           shown_error_reg == -LOST_ERROR ||
                           shown_error_reg == '0))
        else $error("lost line with a centroid error value");

    a_estop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.eval && op_reg == OP_ESTOP) |=>
        (!run_flag_reg && left_speed_reg == '0 && right_speed_reg == '0))
        else $error("emergency stop left the car moving");
`endif

endmodule
